/* rtl/wed_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helper functions for the weighted edit distance block
// depends on nothing; every other file refers to it by scoped names

package wed_pkg;

  // word and pattern sizes
  localparam int MAX_CHARS = 20;
  localparam int PAT_MAX   = 20;
  localparam int ROW_LEN   = MAX_CHARS + 2;

  // derived widths
  localparam int CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int BUF_AW = $clog2(MAX_CHARS);
  localparam int ROW_AW = $clog2(ROW_LEN);
  localparam int PAT_IW = $clog2(PAT_MAX + 1);
  localparam int PAT_AW = $clog2(PAT_MAX);
  localparam int COST_W = 10;
  localparam int SUM_W  = COST_W + 1;
  localparam int DIST_W = 10;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 64;
  localparam logic [CFG_IW-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PAT_MID  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PAT_HIGH = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_PAT_LEN  = 2'd3;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // recurrence costs
  localparam logic [COST_W-1:0] COST_STEP  = 10'd1;
  localparam logic [COST_W-1:0] COST_INDEL = 10'd5;
  localparam logic [COST_W-1:0] COST_EXACT = 10'd0;
  localparam logic [COST_W-1:0] COST_CASE  = 10'd1;
  localparam logic [COST_W-1:0] COST_MISS  = 10'd3;
  localparam int                PEN_SHIFT  = 2;   // penalty of four per extra pattern char
  localparam logic [SUM_W-1:0]  DIST_SAT   = 11'd511;

  // one queued character beat
  typedef struct packed {
    logic [7:0] ch;
    logic       keep;
    logic       last;
  } wed_entry_t;

  // pattern as held in the configuration registers
  typedef struct packed {
    logic [PAT_MAX*8-1:0] chars;
    logic [PAT_IW-1:0]    len;
  } wed_pat_t;

  // ascii upper-casing of a-z
  function automatic logic [7:0] up_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) r = c - 8'h20;
    return r;
  endfunction

  // substitution cost between a pattern char and a word char
  function automatic logic [COST_W-1:0] sub_cost(input logic [7:0] p, input logic [7:0] s);
    logic [COST_W-1:0] r;
    if (p == s) r = COST_EXACT;
    else if (up_ascii(p) == up_ascii(s)) r = COST_CASE;
    else r = COST_MISS;
    return r;
  endfunction

endpackage

/* rtl/wed_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces: word input, configuration write, distance result
// depends on wed_pkg for payload widths

interface wed_word_if;
  logic       valid;
  logic       ready;
  logic [7:0] word_char;
  logic       word_last;
  modport source(output valid, word_char, word_last, input ready);
  modport sink(input valid, word_char, word_last, output ready);
endinterface

interface wed_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wed_pkg::CFG_IW-1:0] cfg_index;
  logic [wed_pkg::CFG_DW-1:0] cfg_data;
  modport source(output valid, cfg_index, cfg_data, input ready);
  modport sink(input valid, cfg_index, cfg_data, output ready);
endinterface

interface wed_dist_if;
  logic                              valid;
  logic                              ready;
  logic signed [wed_pkg::DIST_W-1:0] fuzz_distance;
  modport source(output valid, fuzz_distance, input ready);
  modport sink(input valid, fuzz_distance, output ready);
endinterface

/* rtl/wed_front.sv */
`timescale 1ns / 1ps
// front end: accepts word beats, sorts them into kept, dropped and last
// depends on wed_pkg and wed_word_if; feeds the queue in wed_fifo

module wed_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  wed_word_if.sink            word_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output wed_pkg::wed_entry_t push_data_o
);

  logic [wed_pkg::CNT_W-1:0] kcnt_q, kcnt_d;
  logic                      stop_q, stop_d;
  logic                      keep;
  logic                      accept;

  // a char is kept while the word has room and no zero byte was seen
  assign keep = !stop_q && (word_i.word_char != 8'h00) &&
                (kcnt_q < wed_pkg::CNT_W'(wed_pkg::MAX_CHARS));

  // dropped beats that do not end the word never enter the queue
  assign word_i.ready      = push_ready_i;
  assign accept            = word_i.valid && push_ready_i;
  assign push_valid_o      = word_i.valid && (keep || word_i.word_last);
  assign push_data_o.ch    = word_i.word_char;
  assign push_data_o.keep  = keep;
  assign push_data_o.last  = word_i.word_last;

  // kept count and end-of-word tracking
  always_comb begin
    kcnt_d = kcnt_q;
    stop_d = stop_q;
    if (accept) begin
      if (word_i.word_last) begin
        kcnt_d = '0;
        stop_d = 1'b0;
      end else begin
        if (keep) kcnt_d = kcnt_q + 1'b1;
        if (word_i.word_char == 8'h00) stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcnt_q <= '0;
      stop_q <= 1'b0;
    end else begin
      kcnt_q <= kcnt_d;
      stop_q <= stop_d;
    end
  end

endmodule

/* rtl/wed_fifo.sv */
`timescale 1ns / 1ps
// short queue of character beats between the front and back ends
// depends on wed_pkg for the entry type and depth

module wed_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  wed_pkg::wed_entry_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output wed_pkg::wed_entry_t pop_data_o
);

  wed_pkg::wed_entry_t         mem_q [wed_pkg::FIFO_DEPTH];
  logic [wed_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
  logic [wed_pkg::FIFO_AW:0]   cnt_q;
  logic                        do_push, do_pop;

  assign push_ready_o = (cnt_q != (wed_pkg::FIFO_AW + 1)'(wed_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_ready_i && pop_valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

/* rtl/wed_back.sv */
`timescale 1ns / 1ps
// back end: word buffer, one-cell-per-cycle recurrence sequencer and result register
// depends on wed_pkg and wed_dist_if; drains the queue in wed_fifo

module wed_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wed_pkg::wed_pat_t   pat_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  wed_pkg::wed_entry_t pop_data_i,
  wed_dist_if.source          dist_o
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_CELL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                         state_q, state_d;
  logic [wed_pkg::CNT_W-1:0]          n_q, n_d;
  logic [wed_pkg::CNT_W-1:0]          i_q, i_d;
  logic [wed_pkg::PAT_IW-1:0]         pi_q, pi_d;
  logic [wed_pkg::PAT_IW-1:0]         m_q;
  logic                               dist_valid_q, dist_valid_d;
  logic signed [wed_pkg::DIST_W-1:0]  dist_q;
  logic [7:0]                         buf_q [wed_pkg::MAX_CHARS];
  logic [wed_pkg::COST_W-1:0]         row_q [wed_pkg::ROW_LEN];
  logic [wed_pkg::COST_W-1:0]         prev_q, hold_q;
  logic [wed_pkg::SUM_W-1:0]          sum_q;

  logic [7:0]                         pat_arr [wed_pkg::PAT_MAX];
  logic [wed_pkg::PAT_IW-1:0]         plen_lim, m_calc;
  logic [7:0]                         p_chr, s_chr;
  logic [wed_pkg::ROW_AW-1:0]         rd_idx, wr_idx;
  logic [wed_pkg::COST_W-1:0]         rd_val;
  logic [wed_pkg::COST_W-1:0]         c_step, c_sub, c_del, delta;
  logic [wed_pkg::SUM_W-1:0]          penalty, m_ext, sum_pre;
  logic signed [wed_pkg::DIST_W-1:0]  dist_res;
  logic                               row_end, pass_end, out_free, pop_fire;

  // pattern bytes and effective pattern length (first zero byte or clamped length)
  always_comb begin
    for (int k = 0; k < wed_pkg::PAT_MAX; k++) begin
      pat_arr[k] = pat_i.chars[k*8 +: 8];
    end
    plen_lim = (pat_i.len > wed_pkg::PAT_IW'(wed_pkg::PAT_MAX)) ?
               wed_pkg::PAT_IW'(wed_pkg::PAT_MAX) : pat_i.len;
    m_calc = plen_lim;
    for (int k = wed_pkg::PAT_MAX - 1; k >= 0; k--) begin
      if ((wed_pkg::PAT_IW'(k) < plen_lim) && (pat_arr[k] == 8'h00)) m_calc = wed_pkg::PAT_IW'(k);
    end
  end

  // one recurrence cell: chars with the terminating nul, row reads and the minimum
  assign row_end  = (i_q == n_q);
  assign pass_end = (pi_q == m_q);
  assign p_chr    = pass_end ? 8'h00 : pat_arr[pi_q[wed_pkg::PAT_AW-1:0]];
  assign s_chr    = row_end ? 8'h00 : buf_q[i_q[wed_pkg::BUF_AW-1:0]];
  assign wr_idx   = wed_pkg::ROW_AW'(i_q);
  assign rd_idx   = (state_q == ST_START) ? '0 : wr_idx + 1'b1;
  assign rd_val   = row_q[rd_idx];
  assign c_step   = prev_q + wed_pkg::COST_STEP;
  assign c_sub    = hold_q + wed_pkg::sub_cost(p_chr, s_chr);
  assign c_del    = rd_val + wed_pkg::COST_INDEL;

  always_comb begin
    delta = c_step;
    if (c_sub < delta) delta = c_sub;
    if (c_del < delta) delta = c_del;
  end

  // extra pattern chars penalty and the empty-input shortcuts
  assign penalty = (m_q > n_q) ?
                   ((wed_pkg::SUM_W'(m_q) - wed_pkg::SUM_W'(n_q)) << wed_pkg::PEN_SHIFT) : '0;
  assign m_ext   = wed_pkg::SUM_W'(m_calc);
  assign sum_pre = (m_calc == '0) ? wed_pkg::SUM_W'(1) : (m_ext << 2) + m_ext + 1'b1;

  // final value minus one with saturation
  always_comb begin
    if (sum_q == '0) dist_res = '1;
    else if ((sum_q - 1'b1) > wed_pkg::DIST_SAT) dist_res = wed_pkg::DIST_W'(wed_pkg::DIST_SAT);
    else dist_res = wed_pkg::DIST_W'(sum_q - 1'b1);
  end

  assign out_free     = !dist_valid_q || dist_o.ready;
  assign pop_ready_o  = (state_q == ST_LOAD);
  assign pop_fire     = pop_ready_o && pop_valid_i;
  assign dist_o.valid = dist_valid_q;
  assign dist_o.fuzz_distance = dist_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    i_d          = i_q;
    pi_d         = pi_q;
    dist_valid_d = dist_valid_q && !dist_o.ready;
    unique case (state_q)
      ST_LOAD: begin
        if (pop_fire) begin
          if (pop_data_i.keep) n_d = n_q + 1'b1;
          if (pop_data_i.last) state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        pi_d = '0;
        if ((m_calc == '0) || (n_q == '0)) state_d = ST_DONE;
        else state_d = ST_START;
      end
      ST_START: begin
        i_d     = '0;
        state_d = ST_CELL;
      end
      ST_CELL: begin
        if (row_end) begin
          if (pass_end) begin
            state_d = ST_DONE;
          end else begin
            pi_d    = pi_q + 1'b1;
            state_d = ST_START;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          dist_valid_d = 1'b1;
          n_d          = '0;
          state_d      = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      n_q          <= '0;
      i_q          <= '0;
      pi_q         <= '0;
      dist_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      i_q          <= i_d;
      pi_q         <= pi_d;
      dist_valid_q <= dist_valid_d;
    end
  end

  // datapath: word buffer, cost row, running values, result
  always_ff @(posedge clk_i) begin
    if (pop_fire && pop_data_i.keep) buf_q[n_q[wed_pkg::BUF_AW-1:0]] <= pop_data_i.ch;
    if (state_q == ST_PREP) begin
      for (int k = 0; k < wed_pkg::ROW_LEN; k++) begin
        row_q[k] <= wed_pkg::COST_W'(k);
      end
      m_q   <= m_calc;
      sum_q <= sum_pre;
    end
    if (state_q == ST_START) begin
      hold_q <= rd_val;
      prev_q <= rd_val + wed_pkg::COST_INDEL;
    end
    if (state_q == ST_CELL) begin
      row_q[wr_idx] <= row_end ? delta : prev_q;
      prev_q        <= delta;
      hold_q        <= rd_val;
      if (row_end && pass_end) sum_q <= wed_pkg::SUM_W'(delta) + penalty;
    end
    if ((state_q == ST_DONE) && out_free) dist_q <= dist_res;
  end

  // the cell index never runs past the word end
  a_cell_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |-> (i_q <= n_q))
    else $error("cell index beyond word length");

  // the pass index never runs past the pattern end
  a_pass_in_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CELL) || (state_q == ST_START)) |-> (pi_q <= m_q))
    else $error("pass index beyond pattern length");

  // the kept count stays within the buffer
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= wed_pkg::CNT_W'(wed_pkg::MAX_CHARS))
    else $error("word count beyond buffer depth");

  // handing a result over returns to loading with an empty word
  a_done_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free) |=> ((state_q == ST_LOAD) && (n_q == '0) && dist_valid_q))
    else $error("result handover did not restart loading");

  // the kept count does not change while a cell is computed
  a_pop_only_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |=> (n_q == $past(n_q)))
    else $error("word count changed during compute");

endmodule

/* rtl/weighted_edit_distance.sv */
`timescale 1ns / 1ps
// weighted edit distance between a streamed candidate word and a configured pattern
// depends on wed_pkg, wed_if, wed_front, wed_fifo, wed_back
//
// usage:
//   word_i carries one character per beat; word_last marks the final character.
//   up to 20 characters are kept, a zero byte ends the word, the rest is dropped.
//   cfg_i writes the pattern registers (index 0..3) and is always ready; the user
//   must see it is written only while the block is idle; the block does not check.
//   dist_o delivers one fuzz_distance per word, once the back end has computed it.
// flow:
//   the front takes one beat per cycle, while the queue has room, into a four-entry
//   queue. after the last beat reaches the back end come a setup step, then m+1
//   passes of the single cell unit over the n word chars and the nul (m pattern
//   chars, n word chars), then the load of the output register. an empty word or
//   pattern skips the passes. the next word streams into the queue during compute.
// reset and stalls:
//   reset clears the pattern registers, the counters, the queue and result valid.
//   a result waits in the output register until dist_o.ready; the back end holds
//   the next finished result, and the front stalls once the queue is full.

module weighted_edit_distance (
  input  logic        clk_i,
  input  logic        rst_ni,
  wed_word_if.sink    word_i,
  wed_cfg_if.sink     cfg_i,
  wed_dist_if.source  dist_o
);

  logic [63:0]                 pat_low_q, pat_mid_q;
  logic [31:0]                 pat_high_q;
  logic [wed_pkg::PAT_IW-1:0]  pat_len_q;
  wed_pkg::wed_pat_t           pat;
  logic                        push_valid, push_ready, pop_valid, pop_ready;
  wed_pkg::wed_entry_t         push_data, pop_data;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_mid_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.cfg_index)
        wed_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_i.cfg_data;
        wed_pkg::CFG_PAT_MID:  pat_mid_q  <= cfg_i.cfg_data;
        wed_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_i.cfg_data[31:0];
        wed_pkg::CFG_PAT_LEN:  pat_len_q  <= cfg_i.cfg_data[wed_pkg::PAT_IW-1:0];
        default: ;
      endcase
    end
  end

  assign pat.chars = {pat_high_q, pat_mid_q, pat_low_q};
  assign pat.len   = pat_len_q;

  // front end
  wed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decoupling queue
  wed_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back end
  wed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pat_i       (pat),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .dist_o      (dist_o)
  );

endmodule

/* tb/wed_distance_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the weighted edit distance block: tracks pattern writes and word beats,
// predicts each fuzz_distance and compares it with the result beats; depends on wed_pkg

module wed_distance_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              word_valid_i,
  input  logic                              word_ready_i,
  input  logic [7:0]                        word_char_i,
  input  logic                              word_last_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [wed_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [wed_pkg::CFG_DW-1:0]        cfg_data_i,
  input  logic                              dist_valid_i,
  input  logic                              dist_ready_i,
  input  logic signed [wed_pkg::DIST_W-1:0] fuzz_distance_i,
  output int                                fail_count_o,
  output int                                pending_count_o
);

  localparam int STEP_COST  = 1;
  localparam int INDEL_COST = 5;
  localparam int CASE_COST  = 1;
  localparam int MISS_COST  = 3;
  localparam int EXTRA_PEN  = 4;
  localparam int SAT_LIMIT  = 511;

  // mirrored pattern registers
  logic [63:0] pat_low_q;
  logic [63:0] pat_mid_q;
  logic [31:0] pat_high_q;
  logic [4:0]  pat_len_q;

  // characters of the word being collected
  logic [7:0] kept_chars [wed_pkg::MAX_CHARS];
  int         kept_count;

  logic signed [wed_pkg::DIST_W-1:0] distance_queue [$];
  int                                mismatches;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
  endfunction

  // in-place weighted recurrence over the kept word and the configured pattern
  function automatic logic signed [wed_pkg::DIST_W-1:0] predict_distance();
    logic [wed_pkg::PAT_MAX*8-1:0] all_pat;
    logic [7:0]                    pat [wed_pkg::PAT_MAX+1];
    logic [7:0]                    wrd [wed_pkg::MAX_CHARS+1];
    int                            row [wed_pkg::ROW_LEN];
    int                            m, n, plen, carry, best, cand, sub;
    all_pat = {pat_high_q, pat_mid_q, pat_low_q};
    plen = (pat_len_q > wed_pkg::PAT_MAX) ? wed_pkg::PAT_MAX : int'(pat_len_q);
    m = 0;
    while (m < plen && all_pat[8*m +: 8] != 8'h00) begin
      pat[m] = all_pat[8*m +: 8];
      m++;
    end
    pat[m] = 8'h00;
    n = 0;
    while (n < kept_count && kept_chars[n] != 8'h00) begin
      wrd[n] = kept_chars[n];
      n++;
    end
    wrd[n] = 8'h00;
    best = 0;
    if (m == 0) begin
      best = 1;
    end else if (n == 0) begin
      best = INDEL_COST * m + 1;
    end else begin
      for (int i = 0; i < wed_pkg::ROW_LEN; i++) row[i] = i;
      // the terminating zero of both strings takes part in the passes
      for (int pi = 0; pi <= m; pi++) begin
        carry = row[0] + INDEL_COST;
        for (int i = 0; i <= n; i++) begin
          best = carry + STEP_COST;
          if (pat[pi] == wrd[i]) sub = 0;
          else if (to_upper(pat[pi]) == to_upper(wrd[i])) sub = CASE_COST;
          else sub = MISS_COST;
          cand = sub + row[i];
          if (cand < best) best = cand;
          row[i] = carry;
          cand = row[i+1] + INDEL_COST;
          if (cand < best) best = cand;
          carry = best;
        end
        row[n] = best;
      end
      if (m > n) best += EXTRA_PEN * (m - n);
    end
    if (best == 0) return wed_pkg::DIST_W'(-1);
    if (best - 1 > SAT_LIMIT) return wed_pkg::DIST_W'(SAT_LIMIT);
    return wed_pkg::DIST_W'(best - 1);
  endfunction

  // track config and word beats, compare result beats
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [wed_pkg::DIST_W-1:0] want;
    if (!rst_ni) begin
      pat_low_q  = '0;
      pat_mid_q  = '0;
      pat_high_q = '0;
      pat_len_q  = '0;
      kept_count = 0;
      mismatches = 0;
      distance_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          wed_pkg::CFG_PAT_LOW:  pat_low_q  = cfg_data_i;
          wed_pkg::CFG_PAT_MID:  pat_mid_q  = cfg_data_i;
          wed_pkg::CFG_PAT_HIGH: pat_high_q = cfg_data_i[31:0];
          wed_pkg::CFG_PAT_LEN:  pat_len_q  = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (word_valid_i && word_ready_i) begin
        if (kept_count < wed_pkg::MAX_CHARS) begin
          kept_chars[kept_count] = word_char_i;
          kept_count++;
        end
        if (word_last_i) begin
          distance_queue.push_back(predict_distance());
          kept_count = 0;
        end
      end
      if (dist_valid_i && dist_ready_i) begin
        if (distance_queue.size() == 0) begin
          $error("fuzz_distance: no result expected, got %0d", fuzz_distance_i);
          mismatches++;
        end else begin
          want = distance_queue.pop_front();
          if (fuzz_distance_i !== want) begin
            $error("fuzz_distance: expected %0d, got %0d", want, fuzz_distance_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o    <= mismatches;
    pending_count_o <= distance_queue.size();
  end

endmodule

/* tb/weighted_edit_distance_test.sv */
`timescale 1ns / 1ps
// top of the weighted edit distance testbench: clock, reset, pattern writes, word beats
// and result backpressure; depends on wed_pkg, wed_if, the block and wed_distance_checker

module weighted_edit_distance_test;

  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 500;
  localparam int HOLD_PHASE   = 2;

  logic clk = 1'b0;
  logic rst_n;

  wed_word_if word_if ();
  wed_cfg_if  cfg_if ();
  wed_dist_if dist_if ();

  int fail_total;
  int pending_total;

  // stimulus side bookkeeping
  logic [7:0] pat_bytes [wed_pkg::PAT_MAX];
  int         pat_eff_len;
  int         items_sent;
  bit         word_up;
  bit         smooth;
  int         hold_reqs;
  int         holds_served;

  weighted_edit_distance dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .word_i (word_if),
    .cfg_i  (cfg_if),
    .dist_o (dist_if)
  );

  wed_distance_checker checker_u (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .word_valid_i    (word_if.valid),
    .word_ready_i    (word_if.ready),
    .word_char_i     (word_if.word_char),
    .word_last_i     (word_if.word_last),
    .cfg_valid_i     (cfg_if.valid),
    .cfg_ready_i     (cfg_if.ready),
    .cfg_index_i     (cfg_if.cfg_index),
    .cfg_data_i      (cfg_if.cfg_data),
    .dist_valid_i    (dist_if.valid),
    .dist_ready_i    (dist_if.ready),
    .fuzz_distance_i (dist_if.fuzz_distance),
    .fail_count_o    (fail_total),
    .pending_count_o (pending_total)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (smooth) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [7:0] random_letter();
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
  endfunction

  // word character biased toward the pattern so that distances stay interesting
  function automatic logic [7:0] pick_word_char(input int pos);
    int         roll;
    logic [7:0] c;
    roll = $urandom_range(0, 99);
    if (pat_eff_len > 0 && roll < 50) begin
      c = (pos < pat_eff_len) ? pat_bytes[pos] : pat_bytes[$urandom_range(0, pat_eff_len - 1)];
    end else if (pat_eff_len > 0 && roll < 65) begin
      c = pat_bytes[$urandom_range(0, pat_eff_len - 1)];
      if (c >= 8'h61 && c <= 8'h7a) c = c - 8'h20;
      else if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
    end else if (roll < 85) begin
      c = random_letter();
    end else if (roll < 96) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      c = 8'h00;
    end
    return c;
  endfunction

  function automatic void set_pattern_text(input string s);
    for (int k = 0; k < wed_pkg::PAT_MAX; k++) pat_bytes[k] = (k < s.len()) ? s[k] : 8'h00;
  endfunction

  // write all four pattern registers back to back; dirty fills the unused upper bits
  task automatic write_pattern(input logic [4:0] len_val, input bit dirty);
    logic [wed_pkg::PAT_MAX*8-1:0] packed_chars;
    logic [wed_pkg::CFG_DW-1:0]    reg_vals [4];
    logic [wed_pkg::CFG_IW-1:0]    reg_ids [4];
    int                            lim;
    for (int k = 0; k < wed_pkg::PAT_MAX; k++) packed_chars[8*k +: 8] = pat_bytes[k];
    reg_ids     = '{wed_pkg::CFG_PAT_LOW, wed_pkg::CFG_PAT_MID, wed_pkg::CFG_PAT_HIGH,
                    wed_pkg::CFG_PAT_LEN};
    reg_vals[0] = packed_chars[63:0];
    reg_vals[1] = packed_chars[127:64];
    reg_vals[2] = {(dirty ? 32'($urandom) : 32'h0), packed_chars[159:128]};
    reg_vals[3] = {(dirty ? {27'($urandom), 32'($urandom)} : 59'h0), len_val};
    lim = (len_val > wed_pkg::PAT_MAX) ? wed_pkg::PAT_MAX : int'(len_val);
    pat_eff_len = 0;
    while (pat_eff_len < lim && pat_bytes[pat_eff_len] != 8'h00) pat_eff_len++;
    cfg_if.valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_if.cfg_index <= reg_ids[k];
      cfg_if.cfg_data  <= reg_vals[k];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one word beat, with a random gap ahead of it
  task automatic send_beat(input logic [7:0] ch, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (word_up) begin
        word_if.valid <= 1'b0;
        word_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    word_if.word_char <= ch;
    word_if.word_last <= last;
    if (!word_up) begin
      word_if.valid <= 1'b1;
      word_up = 1'b1;
    end
    do @(posedge clk); while (!word_if.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  // stop offering, wait for every result, then let the block drain
  task automatic settle_idle();
    if (word_up) begin
      word_if.valid <= 1'b0;
      word_up = 1'b0;
    end
    @(posedge clk);
    while (pending_total != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random word of mostly short length, a few overflowing the buffer
  task automatic send_random_word();
    int roll, len;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      send_beat(8'h00, 1'b1);
    end else begin
      if (roll < 85) len = $urandom_range(1, 8);
      else if (roll < 95) len = $urandom_range(9, 20);
      else len = $urandom_range(21, 26);
      for (int i = 0; i < len; i++) send_beat(pick_word_char(i), i == len - 1);
    end
  endtask

  // new random pattern for a phase
  task automatic load_random_pattern();
    int         roll;
    logic [4:0] len_val;
    roll = $urandom_range(0, 99);
    if (roll < 5) len_val = 5'd0;
    else if (roll < 12) len_val = 5'($urandom_range(21, 31));
    else if (roll < 22) len_val = 5'd20;
    else len_val = 5'($urandom_range(1, 12));
    for (int k = 0; k < wed_pkg::PAT_MAX; k++) begin
      pat_bytes[k] = ($urandom_range(0, 9) != 0) ? random_letter() : 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 19) == 0) pat_bytes[$urandom_range(0, wed_pkg::PAT_MAX - 1)] = 8'h00;
    write_pattern(len_val, 1'($urandom_range(0, 1)));
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    dist_if.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_reqs != holds_served) begin
        holds_served++;
        stall = HOLD_CYCLES;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        dist_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dist_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // watchdog
  initial begin : watchdog
    #50_000_000;
    $display("weighted_edit_distance_test failed");
    $finish;
  end

  initial begin : stimulus
    int phase_no;
    int words;
    word_if.valid     = 1'b0;
    word_if.word_char = 8'h00;
    word_if.word_last = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.cfg_index  = wed_pkg::CFG_PAT_LOW;
    cfg_if.cfg_data   = '0;
    rst_n             = 1'b0;
    word_up           = 1'b0;
    smooth            = 1'b0;
    hold_reqs         = 0;
    holds_served      = 0;
    items_sent        = 0;
    pat_eff_len       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pattern registers straight out of reset: empty pattern
    send_beat(8'h61, 1'b1);
    settle_idle();

    // plain pattern: empty word, exact, case-only, short, zero byte inside, top byte
    set_pattern_text("Hello");
    write_pattern(5'd5, 1'b0);
    send_beat(8'h00, 1'b1);
    send_text("Hello");
    send_text("hELLO");
    send_text("Hi");
    send_beat(8'h61, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h71, 1'b1);
    send_beat(8'hff, 1'b1);
    settle_idle();

    // all ones everywhere: length field beyond the pattern size
    for (int k = 0; k < wed_pkg::PAT_MAX; k++) pat_bytes[k] = 8'hff;
    write_pattern(5'd31, 1'b1);
    send_beat(8'hff, 1'b1);
    send_beat(8'h5a, 1'b0);
    send_beat(8'h7a, 1'b1);
    settle_idle();

    // zero byte inside the pattern length
    set_pattern_text("abxcd");
    pat_bytes[2] = 8'h00;
    write_pattern(5'd5, 1'b0);
    send_text("ab");
    settle_idle();

    // characters present but length zero
    set_pattern_text("query");
    write_pattern(5'd0, 1'b0);
    send_beat(8'h78, 1'b1);
    settle_idle();

    // random phases, one of them with the long result hold
    items_sent = 0;
    phase_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      load_random_pattern();
      if (phase_no == HOLD_PHASE) begin
        smooth = 1'b1;
        hold_reqs++;
        words = 16;
      end else begin
        smooth = ($urandom_range(0, 3) == 0);
        words  = $urandom_range(3, 10);
      end
      for (int w = 0; w < words; w++) send_random_word();
      settle_idle();
      phase_no++;
    end
    smooth = 1'b0;

    if (fail_total == 0 && pending_total == 0) begin
      $display("weighted_edit_distance_test passed");
    end else begin
      $display("weighted_edit_distance_test failed");
    end
    $finish;
  end

endmodule
